// ----- src/abmsca_pkg.sv -----
// ----------------------------------------------------------------------------
// abmsca_pkg
// Shared types and constants of the accumulate-before-multiply convolution
// accumulator: sizes, operation codes, register map and item records.
// ----------------------------------------------------------------------------
package abmsca_pkg;

  localparam int PATCH_DEPTH = 1024;
  localparam int LANES       = 8;

  localparam int ADDR_W  = $clog2(PATCH_DEPTH);
  localparam int LANE_IW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W   = $clog2(LANES + 1);

  localparam int OP_W       = 2;
  localparam int PADDR_W    = 10;
  localparam int LANE_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int LOC_W      = 16;
  localparam int WEIGHT_W   = 8;
  localparam int BIAS_W     = 8;
  localparam int LCOUNT_W   = 4;
  localparam int VALUE_W    = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  localparam int STRIDE_W = 10;
  localparam int PROD_W   = LOC_W + STRIDE_W;
  localparam int ENTRY_W  = PROD_W + 1;

  localparam int FRAC_BITS = 31;
  localparam int SUM_W     = SAMPLE_W + FRAC_BITS + 1;
  localparam int Q_W       = SUM_W - FRAC_BITS + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic signed [VALUE_W-1:0] SAT_MAX = 8'sd127;
  localparam logic signed [VALUE_W-1:0] SAT_MIN = -8'sd128;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_LOCATION = 2'd1,
    OP_WEIGHT   = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_BITS  = 3'd0,
    CFG_ROW_BITS     = 3'd1,
    CFG_ROW_STRIDE   = 3'd2,
    CFG_PLANE_STRIDE = 3'd3,
    CFG_ACC_SHIFT    = 3'd4,
    CFG_BIAS_SHIFT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]          column_bits;
    logic [3:0]          row_bits;
    logic [STRIDE_W-1:0] row_stride;
    logic [STRIDE_W-1:0] plane_stride;
    logic signed [4:0]   acc_shift;
    logic signed [4:0]   bias_shift;
  } cfg_t;

  typedef struct packed {
    op_t                        op;
    logic [PADDR_W-1:0]         patch_addr;
    logic [LANE_W-1:0]          lane;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LOC_W-1:0]           location;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [BIAS_W-1:0]   bias;
    logic [LCOUNT_W-1:0]        lane_count;
  } in_item_t;

  typedef struct packed {
    op_t                        op;
    logic [ADDR_W-1:0]          addr;
    logic [LANE_W-1:0]          lane;
    logic [SAMPLE_W-1:0]        sample;
    logic                       in_range;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [BIAS_W-1:0]   bias;
    logic [LCOUNT_W-1:0]        lane_count;
  } q_item_t;

  typedef struct packed {
    logic [LANE_W-1:0]         lane_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      location_error;
  } result_t;

endpackage

// ----- src/abmsca_front.sv -----
// ----------------------------------------------------------------------------
// abmsca_front
// Input side: takes items, splits the packed location into plane, row and
// column, forms the patch entry address and its range check, then queues.
// ----------------------------------------------------------------------------
module abmsca_front (
  input  logic                clk,
  input  logic                rst,
  input  abmsca_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  abmsca_pkg::in_item_t in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output abmsca_pkg::q_item_t q_item
);

  logic                           f1_valid;
  abmsca_pkg::in_item_t           f1_item;
  logic [abmsca_pkg::LOC_W-1:0]   f1_col;
  logic [abmsca_pkg::LOC_W-1:0]   f1_row;
  logic [abmsca_pkg::LOC_W-1:0]   f1_plane;
  logic                           f1_load_ok;

  logic                           f2_valid;
  abmsca_pkg::in_item_t           f2_item;
  logic [abmsca_pkg::LOC_W-1:0]   f2_col;
  logic [abmsca_pkg::PROD_W-1:0]  f2_prod_row;
  logic [abmsca_pkg::PROD_W-1:0]  f2_prod_plane;
  logic                           f2_load_ok;

  logic                           f1_ready;
  logic                           f2_ready;
  logic [abmsca_pkg::LOC_W-1:0]   col_mask;
  logic [abmsca_pkg::LOC_W-1:0]   row_mask;
  logic [4:0]                     plane_shamt;
  logic [abmsca_pkg::ENTRY_W-1:0] entry;

  assign f2_ready = !f2_valid || q_ready;
  assign f1_ready = !f1_valid || f2_ready;
  assign in_ready = f1_ready;

  assign col_mask    = (16'd1 << cfg.column_bits) - 16'd1;
  assign row_mask    = (16'd1 << cfg.row_bits) - 16'd1;
  assign plane_shamt = 5'(cfg.column_bits) + 5'(cfg.row_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_ready) f1_valid <= in_valid;
      if (f2_ready) f2_valid <= f1_valid;
    end
  end

  // split the location
  always_ff @(posedge clk) begin
    if (in_valid && f1_ready) begin
      f1_item    <= in_item;
      f1_col     <= in_item.location & col_mask;
      f1_row     <= (in_item.location >> cfg.column_bits) & row_mask;
      f1_plane   <= in_item.location >> plane_shamt;
      f1_load_ok <= (17'(in_item.patch_addr) < 17'(abmsca_pkg::PATCH_DEPTH)) &&
                    (5'(in_item.lane) < 5'(abmsca_pkg::LANES));
    end
  end

  // stride products
  always_ff @(posedge clk) begin
    if (f1_valid && f2_ready) begin
      f2_item       <= f1_item;
      f2_col        <= f1_col;
      f2_prod_row   <= abmsca_pkg::PROD_W'(f1_row) * abmsca_pkg::PROD_W'(cfg.row_stride);
      f2_prod_plane <= abmsca_pkg::PROD_W'(f1_plane) * abmsca_pkg::PROD_W'(cfg.plane_stride);
      f2_load_ok    <= f1_load_ok;
    end
  end

  assign entry = abmsca_pkg::ENTRY_W'(f2_col) + abmsca_pkg::ENTRY_W'(f2_prod_row) +
                 abmsca_pkg::ENTRY_W'(f2_prod_plane);

  always_comb begin
    q_valid           = f2_valid;
    q_item.op         = f2_item.op;
    q_item.lane       = f2_item.lane;
    q_item.sample     = f2_item.sample;
    q_item.weight     = f2_item.weight;
    q_item.bias       = f2_item.bias;
    q_item.lane_count = f2_item.lane_count;
    if (f2_item.op == abmsca_pkg::OP_LOAD) begin
      q_item.addr     = abmsca_pkg::ADDR_W'(f2_item.patch_addr);
      q_item.in_range = f2_load_ok;
    end else begin
      q_item.addr     = entry[abmsca_pkg::ADDR_W-1:0];
      q_item.in_range = entry < abmsca_pkg::ENTRY_W'(abmsca_pkg::PATCH_DEPTH);
    end
  end

endmodule

// ----- src/abmsca_queue.sv -----
// ----------------------------------------------------------------------------
// abmsca_queue
// Short first-in first-out queue of decoded items between input side and
// execution side.
// ----------------------------------------------------------------------------
module abmsca_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  abmsca_pkg::q_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output abmsca_pkg::q_item_t out_item
);

  abmsca_pkg::q_item_t              slots [abmsca_pkg::QDEPTH];
  logic [abmsca_pkg::QPTR_W-1:0]    wr_ptr;
  logic [abmsca_pkg::QPTR_W-1:0]    rd_ptr;
  logic [abmsca_pkg::QPTR_W:0]      fill;
  logic                             push;
  logic                             pop;

  assign in_ready  = fill != (abmsca_pkg::QPTR_W + 1)'(abmsca_pkg::QDEPTH);
  assign out_valid = fill != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

// ----- src/abmsca_back.sv -----
// ----------------------------------------------------------------------------
// abmsca_back
// Execution side: patch store, group sums, lane accumulators, error flag and
// the scaling unit that turns accumulators into saturated int8 words.
// ----------------------------------------------------------------------------
module abmsca_back (
  input  logic                clk,
  input  logic                rst,
  input  abmsca_pkg::cfg_t    cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  abmsca_pkg::q_item_t q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output abmsca_pkg::result_t out_res
);

  logic                                 advance;
  logic                                 pop;
  logic                                 a_valid;
  abmsca_pkg::q_item_t                  a_item;
  logic                                 do_b;
  logic [abmsca_pkg::SAMPLE_W-1:0]      rdata [abmsca_pkg::LANES];

  logic signed [abmsca_pkg::SAMPLE_W-1:0] group_sum [abmsca_pkg::LANES];
  logic signed [abmsca_pkg::SAMPLE_W-1:0] lane_acc [abmsca_pkg::LANES];
  logic                                   range_error;
  logic signed [abmsca_pkg::SAMPLE_W-1:0] weight16;

  logic                                 fin_active;
  logic [abmsca_pkg::LANE_IW-1:0]       fin_lane;
  logic [abmsca_pkg::CNT_W-1:0]         fin_count;
  logic [abmsca_pkg::CNT_W-1:0]         count_clamped;
  logic                                 fin_err;
  logic signed [abmsca_pkg::SUM_W-1:0]  fin_bias_term;
  logic                                 emit;
  logic                                 fin_last;

  logic [4:0]                           acc_k;
  logic [4:0]                           bias_k;
  logic signed [abmsca_pkg::SUM_W-1:0]  acc_term;
  logic signed [abmsca_pkg::SUM_W-1:0]  sum;
  logic signed [abmsca_pkg::Q_W-1:0]    q_trunc;
  logic                                 neg_frac;
  logic signed [abmsca_pkg::VALUE_W-1:0] sat_value;

  assign advance = !fin_active;
  assign q_ready = advance;
  assign pop     = q_valid && advance;
  assign do_b    = a_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (advance) a_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (pop) a_item <= q_item;
  end

  for (genvar l = 0; l < abmsca_pkg::LANES; l++) begin : g_store
    logic [abmsca_pkg::SAMPLE_W-1:0] mem [abmsca_pkg::PATCH_DEPTH];
    always_ff @(posedge clk) begin
      if (pop && q_item.op == abmsca_pkg::OP_LOAD && q_item.in_range &&
          32'(q_item.lane) == l) begin
        mem[q_item.addr] <= q_item.sample;
      end
      if (pop) rdata[l] <= mem[q_item.addr];
    end
  end

  assign weight16 = abmsca_pkg::SAMPLE_W'(a_item.weight);

  always_comb begin
    if (a_item.lane_count == '0) count_clamped = abmsca_pkg::CNT_W'(1);
    else if (32'(a_item.lane_count) > abmsca_pkg::LANES)
      count_clamped = abmsca_pkg::CNT_W'(abmsca_pkg::LANES);
    else count_clamped = abmsca_pkg::CNT_W'(a_item.lane_count);
  end

  // 2^(shift+16) in units of 2^-31: flip the sign bit
  assign acc_k  = {~cfg.acc_shift[4], cfg.acc_shift[3:0]};
  assign bias_k = {~cfg.bias_shift[4], cfg.bias_shift[3:0]};

  assign emit     = fin_active && (!out_valid || out_ready);
  assign fin_last = (abmsca_pkg::CNT_W'(fin_lane) + 1'b1) == fin_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_error <= 1'b0;
      fin_active  <= 1'b0;
      for (int l = 0; l < abmsca_pkg::LANES; l++) begin
        group_sum[l] <= '0;
        lane_acc[l]  <= '0;
      end
    end else begin
      if (do_b) begin
        case (a_item.op)
          abmsca_pkg::OP_LOCATION: begin
            if (a_item.in_range) begin
              for (int l = 0; l < abmsca_pkg::LANES; l++)
                group_sum[l] <= group_sum[l] + rdata[l];
            end else begin
              range_error <= 1'b1;
            end
          end
          abmsca_pkg::OP_WEIGHT: begin
            for (int l = 0; l < abmsca_pkg::LANES; l++) begin
              lane_acc[l]  <= lane_acc[l] + abmsca_pkg::SAMPLE_W'(group_sum[l] * weight16);
              group_sum[l] <= '0;
            end
          end
          abmsca_pkg::OP_FINISH: fin_active <= 1'b1;
          default: ;
        endcase
      end
      if (emit && fin_last) begin
        fin_active  <= 1'b0;
        range_error <= 1'b0;
        for (int l = 0; l < abmsca_pkg::LANES; l++) begin
          group_sum[l] <= '0;
          lane_acc[l]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_b && a_item.op == abmsca_pkg::OP_FINISH) begin
      fin_lane      <= '0;
      fin_count     <= count_clamped;
      fin_err       <= range_error;
      fin_bias_term <= abmsca_pkg::SUM_W'(a_item.bias) <<< bias_k;
    end else if (emit) begin
      fin_lane <= fin_lane + 1'b1;
    end
  end

  // truncate toward zero, then clamp to int8
  always_comb begin
    acc_term = abmsca_pkg::SUM_W'(lane_acc[fin_lane]) <<< acc_k;
    sum      = acc_term + fin_bias_term;
    neg_frac = sum[abmsca_pkg::SUM_W-1] && (|sum[abmsca_pkg::FRAC_BITS-1:0]);
    q_trunc  = abmsca_pkg::Q_W'($signed(sum[abmsca_pkg::SUM_W-1:abmsca_pkg::FRAC_BITS])) +
               abmsca_pkg::Q_W'({1'b0, neg_frac});
    if (q_trunc > abmsca_pkg::SAT_MAX) sat_value = abmsca_pkg::SAT_MAX;
    else if (q_trunc < abmsca_pkg::SAT_MIN) sat_value = abmsca_pkg::SAT_MIN;
    else sat_value = q_trunc[abmsca_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res.lane_index     <= abmsca_pkg::LANE_W'(fin_lane);
      out_res.value          <= sat_value;
      out_res.last           <= fin_last;
      out_res.location_error <= fin_err;
    end
  end

endmodule

// ----- src/abm_sparse_conv_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// abm_sparse_conv_accumulator_top
// Eight-lane accumulate-before-multiply convolution block.
//
// Input stream s_axis: op in tuser, operands in tdata. Load words fill the
// patch store, location words add a patch entry into the group sums, weight
// words fold the group sums into the lane accumulators, finish words emit
// lane_count (clamped to 1..8) result words on m_axis, the final one with
// tlast set, and then clear sums, accumulators and the location error flag.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle
// by the user, who is bound to it; the block itself does not enforce it.
// Path: split and stride-product stages, queue, execution register; finish
// results leave through the output register. Load, location and weight
// words go at one per cycle unless a finish holds the execution side; a
// finish emits one word per cycle from one scaling unit, slower on a stall.
// A four-entry queue parts the decode pipeline from the execution side, so
// input keeps being taken while a result word waits in the output register.
// Reset: sums, accumulators and flag clear, registers take their defaults;
// the patch store keeps its contents and is undefined until loaded.
// Receiver stall: the output word holds, the finish pauses, the queue fills
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module abm_sparse_conv_accumulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // patch_addr[9:0] lane[12:10] sample[28:13] location[44:29]
  // weight[52:45] bias[60:53] lane_count[64:61], zero above
  input  logic [abmsca_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [abmsca_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // lane_index[2:0] value[10:3] location_error[11], zero above
  output logic [abmsca_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [abmsca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abmsca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  abmsca_pkg::cfg_t     cfg;
  abmsca_pkg::in_item_t in_item;
  abmsca_pkg::q_item_t  fq_item;
  abmsca_pkg::q_item_t  qb_item;
  abmsca_pkg::result_t  res;
  logic                 fq_valid;
  logic                 fq_ready;
  logic                 qb_valid;
  logic                 qb_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_bits  <= 4'd4;
      cfg.row_bits     <= 4'd4;
      cfg.row_stride   <= 10'd3;
      cfg.plane_stride <= 10'd9;
      cfg.acc_shift    <= 5'sd0;
      cfg.bias_shift   <= 5'sd0;
    end else if (cfg_we) begin
      case (abmsca_pkg::cfg_idx_t'(cfg_index))
        abmsca_pkg::CFG_COLUMN_BITS:  cfg.column_bits  <= cfg_data[3:0];
        abmsca_pkg::CFG_ROW_BITS:     cfg.row_bits     <= cfg_data[3:0];
        abmsca_pkg::CFG_ROW_STRIDE:   cfg.row_stride   <= cfg_data;
        abmsca_pkg::CFG_PLANE_STRIDE: cfg.plane_stride <= cfg_data;
        abmsca_pkg::CFG_ACC_SHIFT:    cfg.acc_shift    <= cfg_data[4:0];
        abmsca_pkg::CFG_BIAS_SHIFT:   cfg.bias_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.op         = abmsca_pkg::op_t'(s_axis_tuser);
    in_item.patch_addr = s_axis_tdata[9:0];
    in_item.lane       = s_axis_tdata[12:10];
    in_item.sample     = s_axis_tdata[28:13];
    in_item.location   = s_axis_tdata[44:29];
    in_item.weight     = s_axis_tdata[52:45];
    in_item.bias       = s_axis_tdata[60:53];
    in_item.lane_count = s_axis_tdata[64:61];
  end

  abmsca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  abmsca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  abmsca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {4'd0, res.location_error, res.value, res.lane_index};
  assign m_axis_tlast = res.last;

endmodule

// ----- src/abmsca_checker.sv -----
// ----------------------------------------------------------------------------
// abmsca_checker
// Port-level checks on the result stream of the accumulator top level.
// ----------------------------------------------------------------------------
module abmsca_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [abmsca_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                               m_axis_tlast
);

  logic m_word;

  assign m_word = m_axis_tvalid && m_axis_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_lane_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && $past(!rst) && $past(m_word) && !$past(m_axis_tlast) |->
      m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1)
    else $error("lane index did not step within a finish");

  a_err_steady: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && $past(!rst) && $past(m_word) && !$past(m_axis_tlast) |->
      m_axis_tdata[11] == $past(m_axis_tdata[11]))
    else $error("location error flag changed within a finish");

  a_first_lane: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && $past(!rst) && $past(m_word) && $past(m_axis_tlast) |->
      m_axis_tdata[2:0] == 3'd0)
    else $error("finish did not start at lane zero");

endmodule

bind abm_sparse_conv_accumulator_top abmsca_checker u_abmsca_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
